@@ hw/rtl/serial_command_checksum_handshake_assert.svh @@
// Assertion macros for the serial command checksum handshake block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef SERIAL_COMMAND_CHECKSUM_HANDSHAKE_ASSERT_SVH
`define SERIAL_COMMAND_CHECKSUM_HANDSHAKE_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define SCCH_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("scch assertion failed");

// Check that a condition never holds outside reset.
`define SCCH_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("scch forbidden condition seen");

`else

`define SCCH_ASSERT(label, clk, rst_n, prop)
`define SCCH_NEVER(label, clk, rst_n, expr)

`endif

`endif

@@ hw/rtl/scch_pkg.sv @@
// Shared types and codes for the serial command checksum handshake block.
// No dependencies; used by every RTL file of the block.
package scch_pkg;

	localparam int unsigned QueueDepth = 4;

	localparam logic [1:0] FUNC_START   = 2'd0;
	localparam logic [1:0] FUNC_RX      = 2'd1;
	localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

	localparam logic [2:0] ST_PENDING = 3'd0;
	localparam logic [2:0] ST_SUCCESS = 3'd1;
	localparam logic [2:0] ST_RETRY   = 3'd2;
	localparam logic [2:0] ST_BAD     = 3'd3;
	localparam logic [2:0] ST_TIMEOUT = 3'd4;
	localparam logic [2:0] ST_IGNORED = 3'd5;

	localparam logic [7:0] ACK_REPLY = 8'h55;
	localparam logic [7:0] ACK_CMD   = 8'h00;
	localparam logic [7:0] TRY_MAX   = 8'hff;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] header_byte;
		logic [7:0] code_byte;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic [2:0] status;
		logic       last;
	} out_item_t;

	// One classified item: either a single result or a two-byte command send.
	typedef struct packed {
		logic       dual;
		logic       tx_valid;
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [2:0] status;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

@@ hw/rtl/scch_front.sv @@
// Front end: accepts items, runs the handshake state and classifies each item into a job.
// Depends on scch_pkg.
module scch_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_wdata,
	input  logic                accept,
	input  scch_pkg::in_item_t  item,
	output scch_pkg::job_t      job
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_SUM  = 2'd1;
	localparam logic [1:0] PH_ACK  = 2'd2;

	logic [1:0] phase_q, phase_d;
	logic [7:0] held0_q, held1_q;
	logic [7:0] sum_q;
	logic [7:0] try_q, try_d, try_inc;
	logic [7:0] max_retries_q;
	logic       load_cmd;

	assign try_inc = (try_q == scch_pkg::TRY_MAX) ? try_q : try_q + 8'd1;

	always_comb begin
		job      = '0;
		phase_d  = phase_q;
		try_d    = try_q;
		load_cmd = 1'b0;
		priority if (item.func == scch_pkg::FUNC_START && phase_q != PH_SUM
				&& phase_q != PH_ACK) begin
			load_cmd     = 1'b1;
			job.dual     = 1'b1;
			job.tx_valid = 1'b1;
			job.byte0    = item.header_byte;
			job.byte1    = item.code_byte;
			job.status   = scch_pkg::ST_PENDING;
			phase_d      = PH_SUM;
			try_d        = '0;
		end else if (phase_q == PH_SUM && (item.func == scch_pkg::FUNC_RX
				|| item.func == scch_pkg::FUNC_TIMEOUT)) begin
			if (item.func == scch_pkg::FUNC_RX && item.rx_byte == sum_q) begin
				job.tx_valid = 1'b1;
				job.byte0    = scch_pkg::ACK_CMD;
				job.status   = scch_pkg::ST_PENDING;
				phase_d      = PH_ACK;
			end else begin
				try_d = try_inc;
				if (try_inc < max_retries_q) begin
					// resend the held command
					job.dual     = 1'b1;
					job.tx_valid = 1'b1;
					job.byte0    = held0_q;
					job.byte1    = held1_q;
					job.status   = scch_pkg::ST_PENDING;
				end else begin
					job.status = scch_pkg::ST_RETRY;
					phase_d    = PH_IDLE;
				end
			end
		end else if (phase_q == PH_ACK && (item.func == scch_pkg::FUNC_RX
				|| item.func == scch_pkg::FUNC_TIMEOUT)) begin
			phase_d = PH_IDLE;
			if (item.func == scch_pkg::FUNC_TIMEOUT) begin
				job.status = scch_pkg::ST_TIMEOUT;
			end else if (item.rx_byte == scch_pkg::ACK_REPLY) begin
				job.status = scch_pkg::ST_SUCCESS;
			end else begin
				job.status = scch_pkg::ST_BAD;
			end
		end else begin
			job.status = scch_pkg::ST_IGNORED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			sum_q         <= '0;
			try_q         <= '0;
			max_retries_q <= 8'd5;
		end else begin
			if (cfg_we) begin
				max_retries_q <= cfg_wdata;
			end
			if (accept) begin
				phase_q <= phase_d;
				try_q   <= try_d;
				if (load_cmd) begin
					sum_q <= item.header_byte + item.code_byte;
				end
			end
		end
	end

	// Command bytes are only read after a start has written them.
	always_ff @(posedge clk) begin
		if (accept && load_cmd) begin
			held0_q <= item.header_byte;
			held1_q <= item.code_byte;
		end
	end

endmodule

@@ hw/rtl/scch_queue.sv @@
// Short job queue between front and back end.
// Depends on scch_pkg and the assertion header.
`include "serial_command_checksum_handshake_assert.svh"

module scch_queue #(
	parameter int unsigned DEPTH = scch_pkg::QueueDepth
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  scch_pkg::job_t        push_data,
	input  logic                  pop,
	output scch_pkg::job_t        pop_data,
	output scch_pkg::queue_stat_t stat
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

	scch_pkg::job_t   entries_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             push_ok, pop_ok;

	assign stat.full  = (count_q == CntFull);
	assign stat.empty = (count_q == '0);
	assign push_ok    = push && !stat.full;
	assign pop_ok     = pop && !stat.empty;
	assign pop_data   = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
			end
			unique case ({push_ok, pop_ok})
				2'b10:   count_q <= count_q + CntW'(1);
				2'b01:   count_q <= count_q - CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	`SCCH_ASSERT(a_count_up, clk, arst_n, (push_ok && !pop_ok) |=> count_q == $past(count_q) + CntW'(1))
	`SCCH_NEVER(a_count_range, clk, arst_n, count_q > CntFull)

endmodule

@@ hw/rtl/scch_back.sv @@
// Back end: pops jobs and plays them out as one or two results through an output register.
// Depends on scch_pkg and the assertion header.
`include "serial_command_checksum_handshake_assert.svh"

module scch_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  scch_pkg::job_t        job,
	input  scch_pkg::queue_stat_t qstat,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output scch_pkg::out_item_t   out_data
);

	logic                out_valid_q;
	scch_pkg::out_item_t out_q;
	logic                second_q;
	logic [7:0]          second_byte_q;
	logic                load;

	assign load      = !out_valid_q || !out_stall;
	assign pop       = load && !second_q && !qstat.empty;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else if (load) begin
			priority if (second_q) begin
				out_valid_q <= 1'b1;
				second_q    <= 1'b0;
			end else if (!qstat.empty) begin
				out_valid_q <= 1'b1;
				second_q    <= job.dual;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			priority if (second_q) begin
				out_q.tx_valid <= 1'b1;
				out_q.tx_byte  <= second_byte_q;
				out_q.status   <= scch_pkg::ST_PENDING;
				out_q.last     <= 1'b1;
			end else if (!qstat.empty) begin
				out_q.tx_valid <= job.tx_valid;
				out_q.tx_byte  <= job.byte0;
				out_q.status   <= job.status;
				out_q.last     <= !job.dual;
				second_byte_q  <= job.byte1;
			end else begin
				out_q <= out_q;
			end
		end
	end

	`SCCH_ASSERT(a_second_after_first, clk, arst_n, second_q |-> (out_valid_q && !out_q.last))
	`SCCH_ASSERT(a_first_is_send, clk, arst_n, second_q |-> (out_q.tx_valid && out_q.status == scch_pkg::ST_PENDING))

endmodule

@@ hw/rtl/serial_command_checksum_handshake.sv @@
// Path: each accepted item is written into the job queue, and its results leave through the output register.
// Throughput: one item per cycle while the job queue (QUEUE_DEPTH entries) has room;
// the output register emits one result a cycle while out_stall is low, and a start or resend
// yields two results and every other item one, which sets the sustained rate.
// Reset (arst_n, async, low): phase idle, sum and try count zero, max_retries 5,
// queue and output empty; the held command bytes stay undefined until a start.
module serial_command_checksum_handshake #(
	parameter int unsigned QUEUE_DEPTH = scch_pkg::QueueDepth
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration: max_retries
	input  logic                cfg_we,
	input  logic [7:0]          cfg_wdata,
	// input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  scch_pkg::in_item_t  in_data,
	// result channel
	output logic                out_valid,
	input  logic                out_stall,
	output scch_pkg::out_item_t out_data
);

	scch_pkg::job_t        job_in, job_out;
	scch_pkg::queue_stat_t qstat;
	logic                  in_accept;
	logic                  pop;

	// Hold the input off only when the queue is full; a waiting result
	// in the output register does not block the front.
	assign in_stall  = qstat.full;
	assign in_accept = in_valid && !in_stall;

	// Front: classify each transfer and advance the handshake state.
	scch_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (in_accept),
		.item      (in_data),
		.job       (job_in)
	);

	// Queue: decouple classification from result playback.
	scch_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_accept),
		.push_data (job_in),
		.pop       (pop),
		.pop_data  (job_out),
		.stat      (qstat)
	);

	// Back: play out each job as one or two results.
	scch_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job_out),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
